// ----- src/fmt_pkg.sv -----
// Shared types and constants for the frequency mode tracker.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package fmt_pkg;

  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 2;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_EMPTY_BIT = 64;
  localparam int OUT_DROP_BIT  = 65;

  localparam logic [DATA_W-1:0] COUNT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_t;

endpackage

`default_nettype wire

// ----- src/frequency_mode_tracker_top.sv -----
// Frequency mode tracker: table of distinct values with counts and recency ranks.
// One memory holds key, count and rank per entry, swept by a small sequencer.
// Depends on fmt_pkg.
//
// Use: one item enters on the in_ stream (in_tuser = operation, in_tdata = value)
// and one result leaves on the out_ stream for every item. Write counts a value
// (or inserts it), query reads a count, clear empties the table. Each result also
// carries the most frequent value (most recent wins ties) and an empty flag.
// Flow: a write or query item makes two passes over the entry memory (one read
// port, one write port): a match/free-slot scan, then a rank/count update pass
// that also finds the top entry; a clear skips both passes. An item is not
// taken before the last one's result has gone into the output register.
// in_tready is high only while the sequencer is idle; a finished result sits in
// the output register and the next item may be taken while it waits. If the
// receiver still stalls when the next result is done, the sequencer waits.
// Reset (rst_n low, synchronous) empties the table, drops any pending result and
// sets default_value to 0. cfg_wr_en may be used only while no item is in work.
`default_nettype none

module frequency_mode_tracker_top #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fmt_pkg::DATA_W-1:0]       in_tdata,   // value
  input  logic [fmt_pkg::FUNC_W-1:0]       in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // count [31:0], top_value [63:32], is_empty [64], dropped [65], zero fill
  output logic [fmt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [fmt_pkg::DATA_W-1:0]       cfg_wr_data // default_value
);
  import fmt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [IW-1:0]     rank;
    logic [DATA_W-1:0] cnt;
    logic [DATA_W-1:0] key;
  } ent_t;

  state_t              state_r;
  logic [CW-1:0]       cnt_r;
  logic                rd_vld_r;
  logic [IW-1:0]       rd_idx_r;
  logic [ENTRIES-1:0]  valid_r;
  func_t               func_r;
  logic [DATA_W-1:0]   key_r;
  logic [DATA_W-1:0]   default_r;

  logic                hit_r;
  logic [IW-1:0]       hit_idx_r;
  logic [IW-1:0]       hit_rank_r;
  logic [DATA_W-1:0]   hit_cnt_r;
  logic                free_vld_r;
  logic [IW-1:0]       free_idx_r;

  logic                best_vld_r;
  logic [DATA_W-1:0]   best_cnt_r;
  logic [IW-1:0]       best_rank_r;
  logic [DATA_W-1:0]   best_key_r;

  logic                       out_tvalid_r;
  logic [OUT_TDATA_W-1:0]     out_tdata_r;

  ent_t                mem_r [ENTRIES];
  ent_t                rd_data_r;

  logic [IW-1:0]       rd_addr;
  logic                issue;
  logic                pass_end;
  logic                act_hit;
  logic                act_ins;
  logic                dropped;
  logic [DATA_W-1:0]   new_cnt;
  logic [DATA_W-1:0]   res_cnt;
  logic                scan_match;
  logic                is_new;
  logic                upd_vld;
  ent_t                upd_word;
  logic                wr_en;
  logic                better;

  assign issue    = (cnt_r < LAST_CNT);
  assign rd_addr  = issue ? cnt_r[IW-1:0] : '0;
  assign pass_end = (cnt_r == LAST_CNT) && rd_vld_r;

  assign act_hit = (func_r == FUNC_WRITE) && hit_r;
  assign act_ins = (func_r == FUNC_WRITE) && !hit_r && free_vld_r;
  assign dropped = (func_r == FUNC_WRITE) && !hit_r && !free_vld_r;
  assign new_cnt = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;

  always_comb begin
    unique case (func_r)
      FUNC_WRITE: res_cnt = hit_r ? new_cnt : (free_vld_r ? DATA_W'(1) : '0);
      FUNC_QUERY: res_cnt = hit_r ? hit_cnt_r : '0;
      default:    res_cnt = '0;
    endcase
  end

  assign scan_match = valid_r[rd_idx_r] && (rd_data_r.key == key_r);

  // Update pass: new entry, hit entry moved to rank 0, or rank shift of the others, plus the top-entry compare.
  always_comb begin
    is_new   = act_ins && (rd_idx_r == free_idx_r);
    upd_vld  = valid_r[rd_idx_r] || is_new;
    upd_word = rd_data_r;
    if (is_new) begin
      upd_word.rank = '0;
      upd_word.cnt  = DATA_W'(1);
      upd_word.key  = key_r;
    end else if (act_hit && (rd_idx_r == hit_idx_r)) begin
      upd_word.rank = '0;
      upd_word.cnt  = new_cnt;
    end else if (act_hit && (rd_data_r.rank < hit_rank_r)) begin
      upd_word.rank = rd_data_r.rank + 1'b1;
    end else if (act_ins) begin
      upd_word.rank = rd_data_r.rank + 1'b1;
    end
    wr_en  = (state_r == ST_UPD) && rd_vld_r && upd_vld && (act_hit || act_ins);
    better = upd_vld && (!best_vld_r || (upd_word.cnt > best_cnt_r) ||
             ((upd_word.cnt == best_cnt_r) && (upd_word.rank < best_rank_r)));
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[rd_idx_r] <= upd_word;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      valid_r      <= '0;
      default_r    <= '0;
      hit_r        <= 1'b0;
      free_vld_r   <= 1'b0;
      best_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        default_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      rd_vld_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            func_r     <= func_t'(in_tuser);
            key_r      <= in_tdata;
            hit_r      <= 1'b0;
            free_vld_r <= 1'b0;
            best_vld_r <= 1'b0;
            cnt_r      <= '0;
            if (func_t'(in_tuser) == FUNC_CLEAR) begin
              valid_r <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (issue) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= cnt_r[IW-1:0];
            cnt_r    <= cnt_r + 1'b1;
          end
          if (rd_vld_r) begin
            if (scan_match && !hit_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= rd_idx_r;
              hit_rank_r <= rd_data_r.rank;
              hit_cnt_r  <= rd_data_r.cnt;
            end
            if (!valid_r[rd_idx_r] && !free_vld_r) begin
              free_vld_r <= 1'b1;
              free_idx_r <= rd_idx_r;
            end
          end
          if (pass_end) begin
            cnt_r   <= '0;
            state_r <= ST_UPD;
          end
        end

        ST_UPD: begin
          if (issue) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= cnt_r[IW-1:0];
            cnt_r    <= cnt_r + 1'b1;
          end
          if (rd_vld_r) begin
            if (is_new) begin
              valid_r[rd_idx_r] <= 1'b1;
            end
            if (better) begin
              best_vld_r  <= 1'b1;
              best_cnt_r  <= upd_word.cnt;
              best_rank_r <= upd_word.rank;
              best_key_r  <= upd_word.key;
            end
          end
          if (pass_end) begin
            state_r <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'b0, dropped, !best_vld_r,
                             best_vld_r ? best_key_r : default_r, res_cnt};
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ----- src/fmt_checker.sv -----
// Port-level checks for the frequency mode tracker, bound to the top level.
// Depends on fmt_pkg and frequency_mode_tracker_top.
`default_nettype none

module fmt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fmt_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fmt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a dropped write means a full table: not empty, count zero
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DROP_BIT] |->
      !out_tdata[OUT_EMPTY_BIT] && (out_tdata[DATA_W-1:0] == '0))
    else $error("dropped result with empty flag or nonzero count");

  // nothing can be counted in an empty table
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_EMPTY_BIT] |-> (out_tdata[DATA_W-1:0] == '0))
    else $error("empty table with nonzero count");

  // sequencer is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

endmodule

bind frequency_mode_tracker_top fmt_checker u_fmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
